/* rtl/psh_pkg.sv */
// psh_pkg: sizes, sequencer state type and the bucket hash shared by the pair-sum matcher.
// No dependencies; psh_seq, the top level and the bench refer to it by scoped names.
`default_nettype none

package psh_pkg;

	localparam int DATA_W    = 32;
	localparam int POS_W     = 16;
	localparam int CAPACITY  = 1024;
	localparam int CAP_W     = $clog2(CAPACITY);
	localparam int LINK_W    = $clog2(CAPACITY + 1);
	localparam int BUCKET_W  = 10;
	localparam int BUCKETS   = 1 << BUCKET_W;
	localparam int EPOCH_W   = 8;
	localparam int HEAD_W    = EPOCH_W + LINK_W;
	localparam int ENTRY_W   = DATA_W + LINK_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HEAD,
		ST_HWAIT,
		ST_ENT,
		ST_INS,
		ST_INSW,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             valid;
		logic             found;
		logic [POS_W-1:0] earlier;
		logic [POS_W-1:0] later;
		logic             full;
	} result_t;

	// bucket = |k| mod BUCKETS, k a 33-bit two's complement value
	function automatic logic [BUCKET_W-1:0] bucket_of(input logic [DATA_W:0] k);
		logic [DATA_W:0] mag;
		mag = k[DATA_W] ? ((DATA_W+1)'(0) - k) : k;
		return mag[BUCKET_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/pair_sum_hash_matcher_core.sv */
// Items are taken one at a time: in_ready is high only while the sequencer is idle. An item
// that arrives after its array already has a pair is only counted. An item that is stored
// first walks the chain of its complement's bucket, then inserts itself; once the table is
// full the insert is skipped. An item whose complement lies outside 32 bits skips the walk.
// An item that finds its pair ends the walk at the match. An item with a result (a pair, or
// the last item of an array with no pair) then hands it to the output register and waits
// there while that register holds a result not yet taken. The chain walk through the entry
// ram, one dependent read per cycle, sets the pace of each item. After reset, and after
// every 256th array, a clearing sweep over all 1024 bucket heads runs, during which no item
// is accepted. Configuration writes are taken at any time.
// Top level: holds target_sum, the output register, both rams and psh_seq; uses psh_pkg.
`default_nettype none

module pair_sum_hash_matcher_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic signed [psh_pkg::DATA_W-1:0] target_sum,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [psh_pkg::DATA_W-1:0] value,
	input  wire logic                             last_item,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  found,
	output logic [psh_pkg::POS_W-1:0]             earlier_position,
	output logic [psh_pkg::POS_W-1:0]             later_position,
	output logic                                  table_full
);

	logic [psh_pkg::DATA_W-1:0]   target_q;
	logic                         out_valid_q;
	logic                         out_free;
	psh_pkg::result_t             res;

	logic                         head_we;
	logic [psh_pkg::BUCKET_W-1:0] head_waddr;
	logic [psh_pkg::HEAD_W-1:0]   head_wdata;
	logic [psh_pkg::BUCKET_W-1:0] head_raddr;
	logic [psh_pkg::HEAD_W-1:0]   head_rdata;
	logic                         ent_we;
	logic [psh_pkg::CAP_W-1:0]    ent_waddr;
	logic [psh_pkg::ENTRY_W-1:0]  ent_wdata;
	logic [psh_pkg::CAP_W-1:0]    ent_raddr;
	logic [psh_pkg::ENTRY_W-1:0]  ent_rdata;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				target_q <= target_sum;
			end
			if (res.valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			found            <= res.found;
			earlier_position <= res.earlier;
			later_position   <= res.later;
			table_full       <= res.full;
		end
	end

	psh_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.value      (value),
		.last_item  (last_item),
		.target     (target_q),
		.out_free   (out_free),
		.res        (res),
		.head_we    (head_we),
		.head_waddr (head_waddr),
		.head_wdata (head_wdata),
		.head_raddr (head_raddr),
		.head_rdata (head_rdata),
		.ent_we     (ent_we),
		.ent_waddr  (ent_waddr),
		.ent_wdata  (ent_wdata),
		.ent_raddr  (ent_raddr),
		.ent_rdata  (ent_rdata)
	);

	// bucket heads: {epoch, entry index + 1}
	psh_ram #(
		.DEPTH  (psh_pkg::BUCKETS),
		.WIDTH  (psh_pkg::HEAD_W),
		.ADDR_W (psh_pkg::BUCKET_W)
	) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (head_raddr),
		.rdata (head_rdata)
	);

	// entries: {key, link to next entry + 1}
	psh_ram #(
		.DEPTH  (psh_pkg::CAPACITY),
		.WIDTH  (psh_pkg::ENTRY_W),
		.ADDR_W (psh_pkg::CAP_W)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

endmodule

`default_nettype wire

/* rtl/psh_ram.sv */
// psh_ram: simple dual-port synchronous ram, one write and one read port, registered read.
// Standalone; used for the bucket heads and the entry store.
`default_nettype none

module psh_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/psh_seq.sv */
// psh_seq: per-item sequencer; walks the hash chain, inserts the value, forms the result.
// Depends on psh_pkg; drives the head and entry rams held in the top level.
`default_nettype none

module psh_seq (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [psh_pkg::DATA_W-1:0]      value,
	input  wire logic                            last_item,
	input  wire logic [psh_pkg::DATA_W-1:0]      target,
	input  wire logic                            out_free,
	output psh_pkg::result_t                     res,
	// bucket head ram
	output logic                                 head_we,
	output logic [psh_pkg::BUCKET_W-1:0]         head_waddr,
	output logic [psh_pkg::HEAD_W-1:0]           head_wdata,
	output logic [psh_pkg::BUCKET_W-1:0]         head_raddr,
	input  wire logic [psh_pkg::HEAD_W-1:0]      head_rdata,
	// entry ram
	output logic                                 ent_we,
	output logic [psh_pkg::CAP_W-1:0]            ent_waddr,
	output logic [psh_pkg::ENTRY_W-1:0]          ent_wdata,
	output logic [psh_pkg::CAP_W-1:0]            ent_raddr,
	input  wire logic [psh_pkg::ENTRY_W-1:0]     ent_rdata
);

	psh_pkg::state_t state_q, state_d;

	logic [psh_pkg::DATA_W-1:0]   value_q;
	logic                         last_q;
	logic [psh_pkg::DATA_W:0]     comp_q;
	logic [psh_pkg::POS_W-1:0]    pos_q;
	logic [psh_pkg::POS_W-1:0]    item_pos_q;
	logic [psh_pkg::LINK_W-1:0]   fill_q;
	logic [psh_pkg::LINK_W-1:0]   cur_link_q;
	logic [psh_pkg::EPOCH_W-1:0]  epoch_q;
	logic [psh_pkg::BUCKET_W-1:0] clr_q;
	logic                         pair_done_q;
	logic                         ovf_q;
	logic                         hit_q;

	logic                         accept;
	logic [psh_pkg::DATA_W:0]     comp_in;
	logic                         comp_ok;
	logic [psh_pkg::LINK_W-1:0]   live_link;
	logic [psh_pkg::DATA_W-1:0]   ent_key;
	logic [psh_pkg::LINK_W-1:0]   ent_link;
	logic                         key_hit;
	logic                         has_room;
	logic                         end_array;
	logic                         epoch_wrap;
	logic [psh_pkg::BUCKET_W-1:0] value_bucket;
	logic [psh_pkg::LINK_W-1:0]   earlier_link;
	logic [psh_pkg::LINK_W-1:0]   live_prev;
	logic [psh_pkg::LINK_W-1:0]   ent_prev;

	assign accept     = in_valid && in_ready;
	// exact 33-bit complement; in range only when the top two bits agree
	assign comp_in    = {target[psh_pkg::DATA_W-1], target} - {value[psh_pkg::DATA_W-1], value};
	assign comp_ok    = (comp_in[psh_pkg::DATA_W] == comp_in[psh_pkg::DATA_W-1]);
	// a head written in an earlier array reads as empty
	assign live_link  = (head_rdata[psh_pkg::HEAD_W-1 -: psh_pkg::EPOCH_W] == epoch_q) ?
	                    head_rdata[psh_pkg::LINK_W-1:0] : '0;
	assign ent_key    = ent_rdata[psh_pkg::ENTRY_W-1 -: psh_pkg::DATA_W];
	assign ent_link   = ent_rdata[psh_pkg::LINK_W-1:0];
	assign key_hit    = (ent_key == comp_q[psh_pkg::DATA_W-1:0]);
	assign has_room   = (fill_q < psh_pkg::LINK_W'(psh_pkg::CAPACITY));
	assign epoch_wrap = &epoch_q;
	assign value_bucket = psh_pkg::bucket_of({value_q[psh_pkg::DATA_W-1], value_q});
	assign earlier_link = cur_link_q - psh_pkg::LINK_W'(1);
	assign live_prev  = live_link - psh_pkg::LINK_W'(1);
	assign ent_prev   = ent_link - psh_pkg::LINK_W'(1);
	assign end_array  = (state_q == psh_pkg::ST_IDLE && accept && pair_done_q && last_item) ||
	                    (state_q == psh_pkg::ST_EMIT && out_free && last_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			psh_pkg::ST_CLEAR: begin
				if (clr_q == psh_pkg::BUCKET_W'(psh_pkg::BUCKETS - 1)) begin
					state_d = psh_pkg::ST_IDLE;
				end
			end
			psh_pkg::ST_IDLE: begin
				if (accept) begin
					if (pair_done_q) begin
						state_d = (last_item && epoch_wrap) ? psh_pkg::ST_CLEAR : psh_pkg::ST_IDLE;
					end else begin
						state_d = comp_ok ? psh_pkg::ST_HEAD : psh_pkg::ST_INS;
					end
				end
			end
			psh_pkg::ST_HEAD:  state_d = psh_pkg::ST_HWAIT;
			psh_pkg::ST_HWAIT: begin
				state_d = (live_link == '0) ? psh_pkg::ST_INS : psh_pkg::ST_ENT;
			end
			psh_pkg::ST_ENT: begin
				if (key_hit) begin
					state_d = psh_pkg::ST_EMIT;
				end else if (ent_link == '0) begin
					state_d = psh_pkg::ST_INS;
				end
			end
			psh_pkg::ST_INS: begin
				if (has_room) begin
					state_d = psh_pkg::ST_INSW;
				end else begin
					state_d = last_q ? psh_pkg::ST_EMIT : psh_pkg::ST_IDLE;
				end
			end
			psh_pkg::ST_INSW: state_d = last_q ? psh_pkg::ST_EMIT : psh_pkg::ST_IDLE;
			psh_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = (last_q && epoch_wrap) ? psh_pkg::ST_CLEAR : psh_pkg::ST_IDLE;
				end
			end
			default: state_d = psh_pkg::ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		head_we     = 1'b0;
		head_waddr  = clr_q;
		head_wdata  = '0;
		head_raddr  = psh_pkg::bucket_of(comp_q);
		ent_we      = 1'b0;
		ent_waddr   = fill_q[psh_pkg::CAP_W-1:0];
		ent_wdata   = {value_q, live_link};
		ent_raddr   = earlier_link[psh_pkg::CAP_W-1:0];
		res.valid   = 1'b0;
		res.found   = hit_q;
		res.earlier = hit_q ? psh_pkg::POS_W'(earlier_link[psh_pkg::CAP_W-1:0]) : '0;
		res.later   = hit_q ? item_pos_q : '0;
		res.full    = ovf_q;
		case (state_q)
			psh_pkg::ST_CLEAR: head_we = 1'b1;
			psh_pkg::ST_IDLE:  in_ready = 1'b1;
			psh_pkg::ST_HWAIT: begin
				ent_raddr = live_prev[psh_pkg::CAP_W-1:0];
			end
			psh_pkg::ST_ENT: begin
				ent_raddr = ent_prev[psh_pkg::CAP_W-1:0];
			end
			psh_pkg::ST_INS: head_raddr = value_bucket;
			psh_pkg::ST_INSW: begin
				ent_we     = 1'b1;
				head_we    = 1'b1;
				head_waddr = value_bucket;
				head_wdata = {epoch_q, fill_q + psh_pkg::LINK_W'(1)};
			end
			psh_pkg::ST_EMIT: res.valid = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= psh_pkg::ST_CLEAR;
			clr_q       <= '0;
			epoch_q     <= '0;
			pos_q       <= '0;
			fill_q      <= '0;
			pair_done_q <= 1'b0;
			ovf_q       <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == psh_pkg::ST_CLEAR) begin
				clr_q <= clr_q + psh_pkg::BUCKET_W'(1);
			end
			if (accept) begin
				hit_q <= 1'b0;
				if (pos_q != '1) begin
					pos_q <= pos_q + psh_pkg::POS_W'(1);
				end
			end
			if (state_q == psh_pkg::ST_ENT && key_hit) begin
				hit_q       <= 1'b1;
				pair_done_q <= 1'b1;
			end
			if (state_q == psh_pkg::ST_INS && !has_room) begin
				ovf_q <= 1'b1;
			end
			if (state_q == psh_pkg::ST_INSW) begin
				fill_q <= fill_q + psh_pkg::LINK_W'(1);
			end
			// forget the array: new epoch, wrap forces a clearing sweep
			if (end_array) begin
				pos_q       <= '0;
				fill_q      <= '0;
				pair_done_q <= 1'b0;
				ovf_q       <= 1'b0;
				epoch_q     <= epoch_q + psh_pkg::EPOCH_W'(1);
				clr_q       <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q    <= value;
			last_q     <= last_item;
			comp_q     <= comp_in;
			item_pos_q <= pos_q;
		end
		if (state_q == psh_pkg::ST_HWAIT) begin
			cur_link_q <= live_link;
		end
		if (state_q == psh_pkg::ST_ENT && !key_hit) begin
			cur_link_q <= ent_link;
		end
	end

endmodule

`default_nettype wire

/* sim/pair_sum_hash_matcher_core_tb.sv */
// pair_sum_hash_matcher_core_tb: self-checking bench for the streaming pair-sum matcher.
// Random idling on both sides, a transaction-level predictor of the hash table, in-order result check.
// Depends on psh_pkg and pair_sum_hash_matcher_core only.

module pair_sum_hash_matcher_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     HEADS         = psh_pkg::BUCKETS;
	localparam int     SLOTS         = psh_pkg::CAPACITY;
	localparam int     POS_MAX       = 65535;
	localparam longint WORD_MIN      = -64'sd2147483648;
	localparam longint WORD_MAX      = 64'sd2147483647;
	localparam int     CYCLE_LIMIT   = 400000;
	localparam int     SETTLE_CYCLES = 64;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     MAX_REPORTS   = 10;

	typedef struct packed {
		logic        found;
		logic [15:0] earlier;
		logic [15:0] later;
		logic        full;
	} match_t;

	typedef struct {
		logic signed [31:0] value;
		logic               last;
	} element_t;

	typedef enum int {
		FILL_NEAR_HALF,
		FILL_PLANTED,
		FILL_REPEATS,
		FILL_NOISE
	} fill_mode_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic signed [psh_pkg::DATA_W-1:0] target_sum = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic signed [psh_pkg::DATA_W-1:0] value = '0;
	logic                             last_item = 1'b0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic                             found;
	logic [psh_pkg::POS_W-1:0]        earlier_position;
	logic [psh_pkg::POS_W-1:0]        later_position;
	logic                             table_full;

	pair_sum_hash_matcher_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.target_sum       (target_sum),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.value            (value),
		.last_item        (last_item),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.found            (found),
		.earlier_position (earlier_position),
		.later_position   (later_position),
		.table_full       (table_full)
	);

	always #1 clk = ~clk;

	element_t           array_items[$];
	match_t             pending_matches[$];
	int                 pushed_count = 0;
	int                 accepted_count = 0;
	int                 mismatch_count = 0;
	int                 cycle_count = 0;
	int                 send_gap;
	int                 take_gap;
	int                 hold_left;
	bit                 hold_pending = 1'b0;
	bit                 gaps_on = 1'b1;
	logic signed [31:0] cur_target = '0;

	// predictor copy of the table; heads and links hold slot index + 1, 0 ends a chain
	int unsigned        bucket_head[HEADS];
	logic [31:0]        slot_key[SLOTS];
	int unsigned        slot_link[SLOTS];
	int unsigned        item_pos = 0;
	int unsigned        slots_used = 0;
	bit                 pair_seen = 1'b0;
	bit                 overflowed = 1'b0;
	logic signed [31:0] model_target = '0;

	function automatic int unsigned bucket_index(longint k);
		longint mag;
		mag = (k < 0) ? -k : k;
		return int'(mag % HEADS);
	endfunction

	function automatic void forget_array();
		foreach (bucket_head[i])
			bucket_head[i] = 0;
		item_pos = 0;
		slots_used = 0;
		pair_seen = 1'b0;
		overflowed = 1'b0;
	endfunction

	function automatic void pair_lookup(logic signed [31:0] v, logic last);
		int unsigned pos;
		int unsigned link;
		int unsigned guard;
		int unsigned e;
		int unsigned b;
		longint      comp;
		match_t      r;
		pos = item_pos;
		if (item_pos < POS_MAX)
			item_pos++;
		if (pair_seen) begin
			if (last)
				forget_array();
			return;
		end
		comp = longint'(model_target) - longint'(v);
		// a complement outside 32 bits can never be stored, so skip the walk
		if (comp >= WORD_MIN && comp <= WORD_MAX) begin
			link = bucket_head[bucket_index(comp)];
			guard = 0;
			while (link != 0 && guard < SLOTS) begin
				e = link - 1;
				if (slot_key[e] == comp[31:0]) begin
					r.found = 1'b1;
					r.earlier = e[15:0];
					r.later = pos[15:0];
					r.full = overflowed;
					pending_matches.push_back(r);
					pair_seen = 1'b1;
					if (last)
						forget_array();
					return;
				end
				link = slot_link[e];
				guard++;
			end
		end
		if (slots_used < SLOTS) begin
			b = bucket_index(longint'(v));
			slot_key[slots_used] = v;
			slot_link[slots_used] = bucket_head[b];
			bucket_head[b] = slots_used + 1;
			slots_used++;
		end else begin
			overflowed = 1'b1;
		end
		if (last) begin
			r.found = 1'b0;
			r.earlier = '0;
			r.later = '0;
			r.full = overflowed;
			pending_matches.push_back(r);
			forget_array();
		end
	endfunction

	function automatic void flag_error(string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	function automatic logic signed [31:0] word_of(longint x);
		if (x > WORD_MAX)
			return 32'sh7fffffff;
		if (x < WORD_MIN)
			return 32'sh80000000;
		return x[31:0];
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin : drive
		element_t next_item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			last_item <= 1'b0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				send_gap <= $urandom_range(0, 5);
				in_valid <= 1'b0;
			end else if (array_items.size() != 0) begin
				next_item = array_items.pop_front();
				in_valid <= 1'b1;
				value <= next_item.value;
				last_item <= next_item.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver ready, with the long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			take_gap <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_pending) begin
			hold_pending <= 1'b0;
			hold_left <= HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (take_gap != 0) begin
			take_gap <= take_gap - 1;
			out_ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			take_gap <= $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// predictor update and result check
	always @(posedge clk) begin : watch
		match_t got;
		match_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				model_target = target_sum;
			if (in_valid && in_ready) begin
				pair_lookup(value, last_item);
				accepted_count++;
			end
			if (out_valid && out_ready) begin
				got = '{found, earlier_position, later_position, table_full};
				if (pending_matches.size() == 0) begin
					flag_error($sformatf("unexpected result: found=%0d earlier=%0d later=%0d full=%0d",
						got.found, got.earlier, got.later, got.full));
				end else begin
					want = pending_matches.pop_front();
					if (got.found !== want.found || got.earlier !== want.earlier ||
						got.later !== want.later || got.full !== want.full)
						flag_error($sformatf({"result mismatch: expected found=%0d earlier=%0d ",
							"later=%0d full=%0d, got found=%0d earlier=%0d later=%0d full=%0d"},
							want.found, want.earlier, want.later, want.full,
							got.found, got.earlier, got.later, got.full));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL pair_sum_hash_matcher_core");
			$finish;
		end
	end

	task automatic wait_idle(int settle);
		while (!(accepted_count == pushed_count && pending_matches.size() == 0))
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_target(logic signed [31:0] t);
		wait_idle(SETTLE_CYCLES);
		@(posedge clk);
		cfg_valid <= 1'b1;
		target_sum <= t;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_target = t;
	endtask

	task automatic send(logic signed [31:0] v, logic last);
		array_items.push_back('{v, last});
		pushed_count++;
	endtask

	task automatic send_array(fill_mode_t mode, int len);
		logic signed [31:0] vals[$];
		logic signed [31:0] pick[3];
		logic signed [31:0] a;
		longint             half;
		int                 i;
		int                 j;
		half = longint'(cur_target) >>> 1;
		foreach (pick[k])
			pick[k] = $urandom;
		for (i = 0; i < len; i++) begin
			case (mode)
				FILL_NEAR_HALF: vals.push_back(word_of(half + longint'($urandom_range(0, 40)) - 20));
				FILL_REPEATS:   vals.push_back(pick[$urandom_range(0, 2)]);
				default:        vals.push_back($urandom);
			endcase
		end
		if (len >= 2 && mode == FILL_PLANTED) begin
			i = $urandom_range(0, len - 2);
			j = $urandom_range(i + 1, len - 1);
			a = $urandom;
			if (longint'(word_of(longint'(cur_target) - longint'(a))) !=
				longint'(cur_target) - longint'(a))
				a = cur_target >>> 1;
			vals[i] = a;
			vals[j] = word_of(longint'(cur_target) - longint'(a));
		end else if (len >= 2 && mode == FILL_REPEATS) begin
			// closes on a repeated value, so the hit must name its latest copy
			vals[len-1] = word_of(longint'(cur_target) - longint'(vals[$urandom_range(0, len - 2)]));
		end
		foreach (vals[k])
			send(vals[k], k == len - 1);
	endtask

	task automatic random_phase(int budget);
		int         used;
		int         len;
		fill_mode_t mode;
		used = 0;
		while (used < budget) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: mode = FILL_PLANTED;
				4, 5:       mode = FILL_NEAR_HALF;
				6, 7:       mode = FILL_REPEATS;
				default:    mode = FILL_NOISE;
			endcase
			send_array(mode, len);
			used += len;
		end
	endtask

	initial begin
		int i;
		forget_array();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: hit on last item, lone item, latest copy wins, items after a hit
		write_target(0);
		send(5, 1'b0);
		send(-5, 1'b1);
		send(0, 1'b1);
		send(7, 1'b0);
		send(3, 1'b0);
		send(7, 1'b0);
		send(-7, 1'b0);
		send(9, 1'b0);
		send(1, 1'b1);
		// most negative value lands in bucket 0 and is found there
		write_target(-1);
		send(32'sh80000000, 1'b0);
		send(32'sh7fffffff, 1'b1);
		// complements beyond 32 bits on both sides
		write_target(32'sh7fffffff);
		send(-1, 1'b0);
		send(0, 1'b0);
		send(32'sh7fffffff, 1'b1);
		write_target(32'sh80000000);
		send(1, 1'b0);
		send(32'sh80000000, 1'b0);
		send(0, 1'b1);

		write_target(100);
		hold_pending = 1'b1;
		random_phase(130);
		// sender pauses mid-array until everything has drained
		send(40, 1'b0);
		send(7, 1'b0);
		wait_idle(0);
		send(60, 1'b1);

		write_target($urandom);
		random_phase(130);
		gaps_on = 1'b0;
		write_target(-37);
		random_phase(130);
		gaps_on = 1'b1;
		write_target(32'sh7fffffff);
		random_phase(130);
		write_target(32'sh80000000);
		random_phase(130);
		write_target(0);
		random_phase(100);
		// overflow the table with no pair: positives never sum to zero
		gaps_on = 1'b0;
		for (i = 0; i < SLOTS + 6; i++)
			send($urandom_range(1, 32'h3fffffff), i == SLOTS + 5);

		wait_idle(SETTLE_CYCLES);
		if (mismatch_count == 0 && pending_matches.size() == 0)
			$display("PASS pair_sum_hash_matcher_core");
		else
			$display("FAIL pair_sum_hash_matcher_core");
		$finish;
	end

endmodule

/* filelist.f */
rtl/psh_pkg.sv
rtl/psh_ram.sv
rtl/psh_seq.sv
rtl/pair_sum_hash_matcher_core.sv
sim/pair_sum_hash_matcher_core_tb.sv
